@@ rtl/wost_pkg.sv @@
// ----------------------------------------------------------------------------
// wost_pkg: working order slot tracker package
// Shared codes, item and slot record types and the default table depth.
// ----------------------------------------------------------------------------
package wost_pkg;

  localparam int SLOTS_DEF = 64;
  localparam logic [62:0] STALE_AGE_RST = 63'd5000000000;

  typedef enum logic [1:0] {
    OP_PLACE    = 2'd0,
    OP_FEEDBACK = 2'd1,
    OP_UPDATE   = 2'd2,
    OP_SWEEP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    FB_ACCEPTED     = 3'd0,
    FB_REJECTED     = 3'd1,
    FB_RATE_LIMITED = 3'd2,
    FB_UNAVAILABLE  = 3'd3,
    FB_TIMEOUT      = 3'd4,
    FB_CANCEL_DONE  = 3'd5
  } fb_t;

  typedef enum logic [2:0] {
    ST_LIVE     = 3'd0,
    ST_PARTIAL  = 3'd1,
    ST_FILLED   = 3'd2,
    ST_CANCELED = 3'd3,
    ST_FAILED   = 3'd4,
    ST_OTHER    = 3'd5
  } st_t;

  typedef enum logic [1:0] {
    OC_APPLIED  = 2'd0,
    OC_FULL     = 2'd1,
    OC_NO_MATCH = 2'd2,
    OC_IGNORED  = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_FETCH,
    S_MODIFY,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] client_key;
    logic [63:0] exchange_key;
    logic [63:0] asset_key;
    logic        order_side;
    logic [31:0] limit_price;
    logic [31:0] order_qty;
    logic [31:0] cumulative_fill;
    logic [2:0]  feedback_kind;
    logic [2:0]  order_status;
    logic [62:0] event_time;
    logic [7:0]  quote_level;
  } item_t;

  typedef struct packed {
    logic        used;
    logic [63:0] client;
    logic [63:0] exchange;
    logic [63:0] asset;
    logic        side;
    logic [31:0] price;
    logic [31:0] size;
    logic [31:0] filled;
    logic [62:0] sent_time;
    logic        live;
    logic        pending;
    logic [7:0]  level;
  } slot_rec_t;

  // per-slot compare results of one scan step
  typedef struct packed {
    logic free;
    logic client_hit;
    logic exch_hit;
    logic shape_hit;
    logic stale;
  } eval_t;

endpackage

@@ rtl/wost_if.sv @@
// ----------------------------------------------------------------------------
// wost_if: order item and result channels
// Valid/ready channels carrying one order event in and one result out.
// ----------------------------------------------------------------------------
interface wost_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] client_key;
  logic [63:0] exchange_key;
  logic [63:0] asset_key;
  logic        order_side;
  logic [31:0] limit_price;
  logic [31:0] order_qty;
  logic [31:0] cumulative_fill;
  logic [2:0]  feedback_kind;
  logic [2:0]  order_status;
  logic [62:0] event_time;
  logic [7:0]  quote_level;

  modport source (
    output valid, operation, client_key, exchange_key, asset_key, order_side,
           limit_price, order_qty, cumulative_fill, feedback_kind, order_status,
           event_time, quote_level,
    input  ready
  );
  modport sink (
    input  valid, operation, client_key, exchange_key, asset_key, order_side,
           limit_price, order_qty, cumulative_fill, feedback_kind, order_status,
           event_time, quote_level,
    output ready
  );
endinterface

interface wost_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  logic [5:0] slot_index;
  logic [6:0] removed_count;
  logic [6:0] open_count;

  modport source (
    output valid, outcome, slot_index, removed_count, open_count,
    input  ready
  );
  modport sink (
    input  valid, outcome, slot_index, removed_count, open_count,
    output ready
  );
endinterface

@@ rtl/wost_slot_eval.sv @@
// ----------------------------------------------------------------------------
// wost_slot_eval: slot compare unit
// Matches one slot record against the held item: free, id hits, shape
// candidate against the oldest so far, and staleness.
// ----------------------------------------------------------------------------
module wost_slot_eval import wost_pkg::*; (
  input  slot_rec_t   rec,
  input  item_t       item,
  input  logic [62:0] stale_age,
  input  logic        shape_found,
  input  logic [62:0] oldest,
  output eval_t       ev
);

  logic [62:0] age;

  // age of a pending order at the tick time
  assign age = item.event_time - rec.sent_time;

  always_comb begin
    ev.free       = !rec.used;
    ev.client_hit = rec.used && (item.client_key != '0) && (rec.client == item.client_key);
    ev.exch_hit   = rec.used && (item.exchange_key != '0) &&
                    (rec.exchange == item.exchange_key);
    ev.shape_hit  = rec.used && (rec.exchange == '0) && (item.asset_key != '0) &&
                    (rec.asset == item.asset_key) && (rec.side == item.order_side) &&
                    ((item.limit_price == '0) || (rec.price == item.limit_price)) &&
                    (!shape_found || (rec.sent_time <= oldest));
    ev.stale      = rec.used && rec.pending && (rec.sent_time != '0) &&
                    (item.event_time > rec.sent_time) && (age > stale_age);
  end

endmodule

@@ rtl/working_order_slot_tracker.sv @@
// ----------------------------------------------------------------------------
// working_order_slot_tracker: table of outstanding orders
// Each item is handled by a scan that reads one slot a cycle through the
// single read port of the slot memory, followed by a resolve step and, for
// feedback and updates that match a slot, a read-modify-write of the chosen
// slot; ignored feedback goes straight to the finish step. After reset a
// clearing pass empties the table before the first item is taken.
// ----------------------------------------------------------------------------
module working_order_slot_tracker import wost_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  wost_in_if.sink     in_ch,
  wost_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [62:0] cfg_wr_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t          state, state_next;
  item_t           item;
  logic [62:0]     stale_age;
  logic [AW:0]     idx;
  logic [AW-1:0]   chk;
  logic [AW:0]     cnt;
  logic [AW:0]     res_removed;
  logic [AW-1:0]   res_slot;
  outcome_t        res_outcome;
  logic [AW-1:0]   tgt;
  logic            out_valid;

  // scan trackers
  logic            free_found, cli_found, exch_found, shape_found;
  logic [AW-1:0]   free_idx, cli_idx, exch_idx, shape_idx;
  logic [62:0]     oldest;

  // slot memory
  slot_rec_t       mem [SLOTS];
  slot_rec_t       rdata, wdata;
  logic            we;
  logic [AW-1:0]   waddr, raddr;

  eval_t           ev;
  logic            in_xfer, ignored_fb, sel_found, do_clear;
  logic [AW-1:0]   sel_idx;
  slot_rec_t       mod_rec, place_rec;

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign chk         = AW'(idx - 1'b1);

  assign out_ch.valid = out_valid;

  wost_slot_eval u_eval (
    .rec         (rdata),
    .item        (item),
    .stale_age   (stale_age),
    .shape_found (shape_found),
    .oldest      (oldest),
    .ev          (ev)
  );

  // memory array, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // feedback kinds that leave the table alone
  always_comb begin
    ignored_fb = 1'b0;
    if (in_ch.operation == OP_FEEDBACK) begin
      case (in_ch.feedback_kind)
        FB_ACCEPTED, FB_REJECTED, FB_RATE_LIMITED, FB_UNAVAILABLE,
        FB_CANCEL_DONE: ignored_fb = 1'b0;
        default:        ignored_fb = 1'b1;
      endcase
    end
  end

  // slot choice after the scan
  always_comb begin
    sel_found = 1'b0;
    sel_idx   = '0;
    unique case (item.operation)
      OP_PLACE: begin
        sel_found = free_found;
        sel_idx   = free_idx;
      end
      OP_FEEDBACK: begin
        if (item.feedback_kind == FB_CANCEL_DONE && exch_found) begin
          sel_found = 1'b1;
          sel_idx   = exch_idx;
        end else begin
          sel_found = cli_found;
          sel_idx   = cli_idx;
        end
      end
      OP_UPDATE: begin
        priority if (exch_found) begin
          sel_found = 1'b1;
          sel_idx   = exch_idx;
        end else if (cli_found) begin
          sel_found = 1'b1;
          sel_idx   = cli_idx;
        end else begin
          sel_found = shape_found;
          sel_idx   = shape_idx;
        end
      end
      OP_SWEEP: begin
        sel_found = 1'b0;
      end
    endcase
  end

  // new record for a placed order
  always_comb begin
    place_rec           = '0;
    place_rec.used      = 1'b1;
    place_rec.client    = item.client_key;
    place_rec.asset     = item.asset_key;
    place_rec.side      = item.order_side;
    place_rec.price     = item.limit_price;
    place_rec.size      = item.order_qty;
    place_rec.sent_time = item.event_time;
    place_rec.pending   = 1'b1;
    place_rec.level     = item.quote_level;
  end

  // read-modify-write of the chosen slot
  always_comb begin
    mod_rec  = rdata;
    do_clear = 1'b0;
    if (item.exchange_key != '0) begin
      mod_rec.exchange = item.exchange_key;
    end
    if (item.operation == OP_FEEDBACK) begin
      if (item.feedback_kind == FB_ACCEPTED) begin
        mod_rec.live    = 1'b1;
        mod_rec.pending = 1'b0;
      end else begin
        do_clear = 1'b1;
      end
    end else begin
      case (item.order_status)
        ST_FILLED, ST_CANCELED, ST_FAILED: do_clear = 1'b1;
        ST_LIVE, ST_PARTIAL: begin
          mod_rec.live    = 1'b1;
          mod_rec.pending = 1'b0;
          if (item.order_status == ST_PARTIAL && item.cumulative_fill > rdata.filled) begin
            mod_rec.filled = item.cumulative_fill;
          end
        end
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory port control
  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = chk;
    wdata      = '0;
    raddr      = idx[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        if (idx == (AW+1)'(SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_next = ignored_fb ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx != '0 && item.operation == OP_SWEEP && ev.stale) begin
          we = 1'b1;
        end
        if (idx == (AW+1)'(SLOTS)) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (item.operation == OP_PLACE && sel_found) begin
          we    = 1'b1;
          waddr = sel_idx;
          wdata = place_rec;
        end
        if (item.operation == OP_PLACE || item.operation == OP_SWEEP || !sel_found) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        raddr      = tgt;
        state_next = S_MODIFY;
      end
      S_MODIFY: begin
        we         = 1'b1;
        waddr      = tgt;
        wdata      = do_clear ? '0 : mod_rec;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ch.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      stale_age <= STALE_AGE_RST;
    end else begin
      if (cfg_wr_en) begin
        stale_age <= cfg_wr_data;
      end
      // result taken and no new one loaded behind it
      if (out_valid && out_ch.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          idx <= (idx == (AW+1)'(SLOTS - 1)) ? '0 : idx + 1'b1;
        end
        S_IDLE: begin
          if (in_xfer) begin
            item.operation       <= in_ch.operation;
            item.client_key      <= in_ch.client_key;
            item.exchange_key    <= in_ch.exchange_key;
            item.asset_key       <= in_ch.asset_key;
            item.order_side      <= in_ch.order_side;
            item.limit_price     <= in_ch.limit_price;
            item.order_qty       <= in_ch.order_qty;
            item.cumulative_fill <= in_ch.cumulative_fill;
            item.feedback_kind   <= in_ch.feedback_kind;
            item.order_status    <= in_ch.order_status;
            item.event_time      <= in_ch.event_time;
            item.quote_level     <= in_ch.quote_level;
            idx                  <= '0;
            free_found           <= 1'b0;
            cli_found            <= 1'b0;
            exch_found           <= 1'b0;
            shape_found          <= 1'b0;
            res_removed          <= '0;
            res_slot             <= '0;
            res_outcome          <= OC_IGNORED;
          end
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (idx != '0) begin
            if (ev.free && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk;
            end
            if (ev.client_hit && !cli_found) begin
              cli_found <= 1'b1;
              cli_idx   <= chk;
            end
            if (ev.exch_hit && !exch_found) begin
              exch_found <= 1'b1;
              exch_idx   <= chk;
            end
            if (ev.shape_hit) begin
              shape_found <= 1'b1;
              shape_idx   <= chk;
              oldest      <= rdata.sent_time;
            end
            if (item.operation == OP_SWEEP && ev.stale) begin
              res_removed <= res_removed + 1'b1;
              cnt         <= cnt - 1'b1;
            end
          end
        end
        S_RESOLVE: begin
          tgt      <= sel_idx;
          res_slot <= sel_found ? sel_idx : '0;
          if (item.operation == OP_SWEEP) begin
            res_outcome <= OC_APPLIED;
          end else if (sel_found) begin
            res_outcome <= OC_APPLIED;
          end else if (item.operation == OP_PLACE) begin
            res_outcome <= OC_FULL;
          end else begin
            res_outcome <= OC_NO_MATCH;
          end
          if (item.operation == OP_PLACE && sel_found) begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FETCH: ;
        S_MODIFY: begin
          if (do_clear) begin
            cnt         <= cnt - 1'b1;
            res_removed <= (AW+1)'(1);
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ch.ready) begin
            out_valid            <= 1'b1;
            out_ch.outcome       <= res_outcome;
            out_ch.slot_index    <= 6'(res_slot);
            out_ch.removed_count <= 7'(res_removed);
            out_ch.open_count    <= 7'(cnt);
          end
        end
        default: ;
      endcase
    end
  end

  // occupancy never exceeds the table
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW+1)'(SLOTS))
    else $error("working count above table depth");

  // writes during a scan occur only for a sweep
  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    (we && state == S_SCAN) |-> (item.operation == OP_SWEEP))
    else $error("slot write during a non-sweep scan");

  // a result only appears out of the finish step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result raised outside finish");

  // a placed order adds exactly one working slot
  a_place_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESOLVE && item.operation == OP_PLACE && sel_found) |=>
      (cnt == $past(cnt) + 1'b1))
    else $error("place did not raise working count");

endmodule

@@ bench/tb_working_order_slot_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_working_order_slot_tracker: regression for the working order slot tracker
// Drives place, feedback, update and sweep events over valid/ready channels,
// predicts each result from a model of the slot table and compares per field.
// ----------------------------------------------------------------------------
module tb_working_order_slot_tracker;
  import wost_pkg::*;

  typedef struct {
    logic [1:0] outcome;
    logic [5:0] slot_index;
    logic [6:0] removed_count;
    logic [6:0] open_count;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [62:0] cfg_wr_data = '0;

  wost_in_if in_ch ();
  wost_out_if out_ch ();

  working_order_slot_tracker u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted table
  slot_rec_t tbl [SLOTS_DEF];
  logic [62:0] stale_limit;
  result_t expected_q [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [62:0] clock_ns = 63'd1000;
  logic [63:0] key_seq = 64'd100;

  function automatic int find_client(logic [63:0] key);
    if (key == 0) return -1;
    for (int k = 0; k < SLOTS_DEF; k++)
      if (tbl[k].used && tbl[k].client == key) return k;
    return -1;
  endfunction

  function automatic int find_exchange(logic [63:0] key);
    if (key == 0) return -1;
    for (int k = 0; k < SLOTS_DEF; k++)
      if (tbl[k].used && tbl[k].exchange == key) return k;
    return -1;
  endfunction

  // oldest uncorrelated slot of same shape, ties go to highest index
  function automatic int find_shape(logic [63:0] asset, logic side, logic [31:0] price);
    int best;
    logic [63:0] oldest;
    best = -1;
    oldest = '1;
    if (asset == 0) return -1;
    for (int k = 0; k < SLOTS_DEF; k++) begin
      if (!tbl[k].used || tbl[k].exchange != 0) continue;
      if (tbl[k].asset != asset || tbl[k].side != side) continue;
      if (price != 0 && tbl[k].price != price) continue;
      if ({1'b0, tbl[k].sent_time} <= oldest) begin
        oldest = {1'b0, tbl[k].sent_time};
        best = k;
      end
    end
    return best;
  endfunction

  function automatic result_t apply_event(item_t it);
    result_t r;
    int slot;
    int removed;
    int working;
    slot = -1;
    removed = 0;
    working = 0;
    r.outcome = OC_APPLIED;
    case (it.operation)
      OP_PLACE: begin
        for (int k = 0; k < SLOTS_DEF; k++)
          if (!tbl[k].used) begin
            slot = k;
            break;
          end
        if (slot < 0) begin
          r.outcome = OC_FULL;
        end else begin
          tbl[slot] = '0;
          tbl[slot].used = 1'b1;
          tbl[slot].client = it.client_key;
          tbl[slot].asset = it.asset_key;
          tbl[slot].side = it.order_side;
          tbl[slot].price = it.limit_price;
          tbl[slot].size = it.order_qty;
          tbl[slot].sent_time = it.event_time;
          tbl[slot].pending = 1'b1;
          tbl[slot].level = it.quote_level;
        end
      end
      OP_FEEDBACK: begin
        if (it.feedback_kind == FB_ACCEPTED) begin
          slot = find_client(it.client_key);
          if (slot < 0) r.outcome = OC_NO_MATCH;
          else begin
            tbl[slot].pending = 1'b0;
            tbl[slot].live = 1'b1;
            if (it.exchange_key != 0) tbl[slot].exchange = it.exchange_key;
          end
        end else if (it.feedback_kind inside {FB_REJECTED, FB_RATE_LIMITED,
                                              FB_UNAVAILABLE, FB_CANCEL_DONE}) begin
          if (it.feedback_kind == FB_CANCEL_DONE) begin
            slot = find_exchange(it.exchange_key);
            if (slot < 0) slot = find_client(it.client_key);
          end else begin
            slot = find_client(it.client_key);
          end
          if (slot < 0) r.outcome = OC_NO_MATCH;
          else begin
            tbl[slot] = '0;
            removed = 1;
          end
        end else begin
          r.outcome = OC_IGNORED;
        end
      end
      OP_UPDATE: begin
        slot = find_exchange(it.exchange_key);
        if (slot < 0) slot = find_client(it.client_key);
        if (slot < 0) slot = find_shape(it.asset_key, it.order_side, it.limit_price);
        if (slot < 0) r.outcome = OC_NO_MATCH;
        else begin
          if (it.exchange_key != 0) tbl[slot].exchange = it.exchange_key;
          if (it.order_status inside {ST_FILLED, ST_CANCELED, ST_FAILED}) begin
            tbl[slot] = '0;
            removed = 1;
          end else if (it.order_status inside {ST_LIVE, ST_PARTIAL}) begin
            if (it.order_status == ST_PARTIAL && it.cumulative_fill > tbl[slot].filled)
              tbl[slot].filled = it.cumulative_fill;
            tbl[slot].live = 1'b1;
            tbl[slot].pending = 1'b0;
          end
        end
      end
      default: begin
        for (int k = 0; k < SLOTS_DEF; k++) begin
          if (!tbl[k].used || !tbl[k].pending) continue;
          if (tbl[k].sent_time > 0 && it.event_time > tbl[k].sent_time &&
              it.event_time - tbl[k].sent_time > stale_limit) begin
            tbl[k] = '0;
            removed++;
          end
        end
        slot = -1;
      end
    endcase
    for (int k = 0; k < SLOTS_DEF; k++)
      if (tbl[k].used) working++;
    r.slot_index = (slot < 0) ? 6'd0 : slot[5:0];
    r.removed_count = removed[6:0];
    r.open_count = working[6:0];
    return r;
  endfunction

  // send one order event, predict at the transfer
  task automatic send_event(item_t it);
    // valid of the last transfer was dropped when that transfer ended; raise it at a later falling edge
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.operation <= it.operation;
    in_ch.client_key <= it.client_key;
    in_ch.exchange_key <= it.exchange_key;
    in_ch.asset_key <= it.asset_key;
    in_ch.order_side <= it.order_side;
    in_ch.limit_price <= it.limit_price;
    in_ch.order_qty <= it.order_qty;
    in_ch.cumulative_fill <= it.cumulative_fill;
    in_ch.feedback_kind <= it.feedback_kind;
    in_ch.order_status <= it.order_status;
    in_ch.event_time <= it.event_time;
    in_ch.quote_level <= it.quote_level;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(apply_event(it));
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk)
    out_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);

  // result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0d/%0d/%0d/%0d", $time,
                 out_ch.outcome, out_ch.slot_index, out_ch.removed_count,
                 out_ch.open_count);
        errors++;
      end else begin
        result_t e;
        e = expected_q.pop_front();
        if (e.outcome !== out_ch.outcome) begin
          $display("%0t outcome: expected %0d actual %0d", $time, e.outcome, out_ch.outcome);
          errors++;
        end
        if (e.slot_index !== out_ch.slot_index) begin
          $display("%0t slot_index: expected %0d actual %0d", $time, e.slot_index,
                   out_ch.slot_index);
          errors++;
        end
        if (e.removed_count !== out_ch.removed_count) begin
          $display("%0t removed_count: expected %0d actual %0d", $time, e.removed_count,
                   out_ch.removed_count);
          errors++;
        end
        if (e.open_count !== out_ch.open_count) begin
          $display("%0t open_count: expected %0d actual %0d", $time, e.open_count,
                   out_ch.open_count);
          errors++;
        end
      end
    end
  end

  task automatic drain;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_stale_age(logic [62:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    stale_limit = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t blank_event(logic [1:0] op);
    item_t it;
    it = '0;
    it.operation = op;
    return it;
  endfunction

  function automatic item_t place_event(logic [63:0] ck, logic [63:0] ak, logic side,
                                        logic [31:0] price, logic [62:0] t);
    item_t it;
    it = blank_event(OP_PLACE);
    it.client_key = ck;
    it.asset_key = ak;
    it.order_side = side;
    it.limit_price = price;
    it.order_qty = $urandom;
    it.event_time = t;
    it.quote_level = 8'($urandom);
    return it;
  endfunction

  // directed: extremes, full table, every feedback, all statuses but other, ties, sweep
  task automatic test_directed;
    item_t it;
    it = place_event('1, '1, 1'b1, '1, '1);
    it.order_qty = '1;
    it.quote_level = '1;
    send_event(it);
    it = blank_event(OP_FEEDBACK);
    it.client_key = '1;
    it.exchange_key = '1;
    send_event(it);
    it = blank_event(OP_UPDATE);
    it.exchange_key = '1;
    it.order_status = ST_PARTIAL;
    it.cumulative_fill = '1;
    send_event(it);
    it.cumulative_fill = 32'd5;
    send_event(it);
    it.order_status = 3'd7;
    send_event(it);
    it.order_status = ST_FILLED;
    send_event(it);
    // absent keys and misses
    send_event(blank_event(OP_FEEDBACK));
    send_event(blank_event(OP_UPDATE));
    it = blank_event(OP_FEEDBACK);
    it.feedback_kind = FB_TIMEOUT;
    send_event(it);
    it.feedback_kind = 3'd7;
    send_event(it);
    // fallback ties on equal send times
    send_event(place_event(64'd0, 64'd9, 1'b0, 32'd10, 63'd50));
    send_event(place_event(64'd0, 64'd9, 1'b0, 32'd10, 63'd50));
    it = blank_event(OP_UPDATE);
    it.asset_key = 64'd9;
    it.order_status = ST_LIVE;
    send_event(it);
    it.order_status = ST_CANCELED;
    it.limit_price = 32'd10;
    send_event(it);
    it.order_status = ST_FAILED;
    send_event(it);
    // fill the table and overflow
    for (int i = 0; i < SLOTS_DEF + 1; i++)
      send_event(place_event(64'd1000 + i, 64'd3, i[0], 32'd7, (i < 3) ? 63'd0 : 63'd100));
    it = blank_event(OP_FEEDBACK);
    it.feedback_kind = FB_REJECTED;
    it.client_key = 64'd1001;
    send_event(it);
    it.feedback_kind = FB_RATE_LIMITED;
    it.client_key = 64'd1002;
    send_event(it);
    it.feedback_kind = FB_UNAVAILABLE;
    it.client_key = 64'd1003;
    send_event(it);
    it.feedback_kind = FB_CANCEL_DONE;
    it.client_key = 64'd1004;
    send_event(it);
    it = blank_event(OP_SWEEP);
    it.event_time = '1;
    send_event(it);
  endtask

  function automatic item_t random_event();
    item_t it;
    int used_k [$];
    int pick;
    int u;
    logic [383:0] raw;
    it = '0;
    it.order_side = 1'($urandom);
    it.order_qty = $urandom;
    it.quote_level = 8'($urandom);
    it.cumulative_fill = $urandom_range(3) == 0 ? $urandom : $urandom_range(500);
    for (int k = 0; k < SLOTS_DEF; k++) if (tbl[k].used) used_k.push_back(k);
    clock_ns += 63'($urandom_range(200));
    pick = $urandom_range(99);
    if (pick < 35 || used_k.size() == 0) begin
      key_seq++;
      it.operation = OP_PLACE;
      it.client_key = $urandom_range(9) == 0 ? 64'd0 : key_seq;
      it.asset_key = 64'($urandom_range(3));
      it.limit_price = $urandom_range(3);
      it.event_time = $urandom_range(19) == 0 ? 63'd0 : clock_ns;
    end else if (pick < 92) begin
      u = used_k[$urandom_range(used_k.size() - 1)];
      it.operation = (pick < 62) ? OP_FEEDBACK : OP_UPDATE;
      it.client_key = $urandom_range(4) == 0 ? 64'd0 : tbl[u].client;
      it.exchange_key = $urandom_range(1) ? tbl[u].exchange :
                        ($urandom_range(1) ? 64'd0 : rand64());
      it.asset_key = $urandom_range(5) == 0 ? 64'd0 : tbl[u].asset;
      it.order_side = $urandom_range(5) == 0 ? ~tbl[u].side : tbl[u].side;
      it.limit_price = $urandom_range(1) ? tbl[u].price : 32'd0;
      it.feedback_kind = 3'($urandom_range(2) == 0 ? $urandom_range(7) :
                            $urandom_range(1) * 5);
      it.order_status = 3'($urandom_range(1) ? $urandom_range(1) : $urandom_range(7));
    end else if (pick < 97) begin
      it.operation = OP_SWEEP;
      it.event_time = $urandom_range(3) == 0 ? 63'({$urandom, $urandom}) : clock_ns;
    end else begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(item_t)-1:0];
      if (it.operation == OP_SWEEP) it.event_time = clock_ns;
    end
    return it;
  endfunction

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_event(random_event());
  endtask

  task automatic test_stale_settings;
    write_stale_age(63'd300);
    test_random(150);
    write_stale_age('1);
    test_random(100);
    write_stale_age(63'd0);
    test_random(150);
  endtask

  initial begin
    for (int k = 0; k < SLOTS_DEF; k++) tbl[k] = '0;
    stale_limit = STALE_AGE_RST;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.client_key = '0;
    in_ch.exchange_key = '0;
    in_ch.asset_key = '0;
    in_ch.order_side = 1'b0;
    in_ch.limit_price = '0;
    in_ch.order_qty = '0;
    in_ch.cumulative_fill = '0;
    in_ch.feedback_kind = '0;
    in_ch.order_status = '0;
    in_ch.event_time = '0;
    in_ch.quote_level = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    send_idle_pct = 36;
    recv_idle_pct = 46;
    test_random(200);
    drain();
    send_idle_pct = 46;
    recv_idle_pct = 36;
    test_stale_settings();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_stale_age(63'd5000000000);
    test_random(265);
    drain();
    if (errors == 0) begin
      $display("working_order_slot_tracker regression: pass");
    end else begin
      $display("working_order_slot_tracker regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("working_order_slot_tracker regression: fail");
    $finish;
  end
endmodule
